// ----- hw/rtl/tcw_pkg.sv -----
// Shared types and codes for the text console writer.
// Holds the controller/datapath command and status structs and the mode codes.
// No dependencies.
`default_nettype none

package tcw_pkg;

  // Operation codes carried in the input tuser field.
  localparam logic [1:0] MODE_PUT  = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Character codes that move the cursor to the start of the next row.
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted input item
    logic exec;        // carry out the latched item on cursor and store
    logic clear_step;  // write one zero cell during the reset sweep
    logic copy_step;   // move one cell up one row during a scroll
    logic fill_step;   // write one bottom-row cell during a scroll
    logic load_out;    // load the result register
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic scroll_needed;  // the latched item steps past the last row
    logic move_end;       // sweep counter is on the last cell to move
    logic cnt_end;        // sweep counter is on the last cell of the store
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/text_console_writer.sv -----
// Text console writer top level: a character-cell screen with a cursor.
// Input items (mode in s_tuser) go in on the slave stream; each gives one
// result item on the master stream. Configuration sets the fill attribute.
// Put-character writes the byte and fill attribute at the cursor and moves
// the cursor; newline and carriage return go to column 0 of the next row.
// Set-cursor clamps its target to the screen; read-cell returns one cell.
// Timing: an item is taken in IDLE, executed in EXEC and its result loaded
// into the output register in FINISH; the next item is accepted only back in
// IDLE, so items do not overlap. A step past the last row walks the screen
// store through its single read and single write port, copying every cell
// below the top row up one row and then filling the bottom row.
// After reset a clearing pass writes zero to every cell, one per cycle;
// no item is accepted meanwhile, while configuration writes are taken at
// any time. The fill attribute resets to 7.
// If the receiver stalls, a finished result waits in the output register;
// one more item is accepted and held until that register frees up.
`default_nettype none

module text_console_writer #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_LINES   = 25
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data,  // fill_attribute
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,      // char_code[7:0], col[14:8], row[19:15], zero[23:20]
  input  wire  [1:0]  s_tuser,      // mode[1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata       // cursor_x[6:0], cursor_y[11:7], cell_char[19:12],
                                    // cell_attr[27:20], scrolled[28], zero[31:29]
);
  import tcw_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic [6:0] cursor_x;
  logic [4:0] cursor_y;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;
  logic       scrolled;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_LINES   (SCREEN_LINES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_mode      (s_tuser),
    .in_char_code (s_tdata[7:0]),
    .in_col       (s_tdata[14:8]),
    .in_row       (s_tdata[19:15]),
    .cursor_x     (cursor_x),
    .cursor_y     (cursor_y),
    .cell_char    (cell_char),
    .cell_attr    (cell_attr),
    .scrolled     (scrolled)
  );

  // Pack the result fields, highest field first.
  assign m_tdata = {3'b000, scrolled, cell_attr, cell_char, cursor_y, cursor_x};

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_ctrl.sv -----
// Controller state machine for the text console writer.
// Sequences the reset sweep, item execution, scroll and result handoff.
// Depends on tcw_pkg.
`default_nettype none

module tcw_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  wire              m_tready,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t    cmd
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_FILL,
    ST_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Command decode from the current state.
  always_comb begin
    cmd            = '0;
    cmd.capture    = (state == ST_IDLE) && s_tvalid;
    cmd.exec       = (state == ST_EXEC);
    cmd.clear_step = (state == ST_CLEAR);
    cmd.copy_step  = (state == ST_COPY);
    cmd.fill_step  = (state == ST_FILL);
    cmd.load_out   = (state == ST_FINISH) && out_free;
  end

  // State register and the registered output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (status.cnt_end) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (status.scroll_needed) state <= ST_COPY;
          else                      state <= ST_FINISH;
        end
        ST_COPY: begin
          if (status.move_end) state <= ST_FILL;
        end
        ST_FILL: begin
          if (status.cnt_end) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_datapath.sv -----
// Datapath for the text console writer: screen store, cursor, sweep counter,
// fill attribute register and result register.
// Depends on tcw_pkg; driven by tcw_ctrl commands.
`default_nettype none

module tcw_datapath #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_LINES   = 25
) (
  input  wire              clk,
  input  wire              rst,
  input  tcw_pkg::cmd_t    cmd,
  output tcw_pkg::status_t status,
  input  wire              cfg_wr_en,
  input  wire  [7:0]       cfg_wr_data,
  input  wire  [1:0]       in_mode,
  input  wire  [7:0]       in_char_code,
  input  wire  [6:0]       in_col,
  input  wire  [4:0]       in_row,
  output logic [6:0]       cursor_x,
  output logic [4:0]       cursor_y,
  output logic [7:0]       cell_char,
  output logic [7:0]       cell_attr,
  output logic             scrolled
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_LINES;
  localparam int MOVE_COUNT = CELL_COUNT - SCREEN_COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(SCREEN_COLUMNS);
  localparam int RW         = $clog2(SCREEN_LINES);

  // Screen store: char in bits 7..0, attribute in bits 15..8.
  logic [15:0]       mem [CELL_COUNT];
  logic [15:0]       rd_data;

  logic [7:0]        fill_attr;
  logic [CW-1:0]     cur_col;
  logic [RW-1:0]     cur_row;
  logic [ADDR_W-1:0] cnt;

  logic [1:0]        item_mode;
  logic [7:0]        item_char;
  logic [6:0]        item_col;
  logic [4:0]        item_row;
  logic              scroll_flag;

  // Delayed write stage shared by the scroll copy and fill.
  logic              pend_valid;
  logic              pend_fill;
  logic [ADDR_W-1:0] pend_addr;

  logic              is_put;
  logic              is_newline;
  logic              col_last;
  logic              row_last;
  logic              put_wr;
  logic [CW-1:0]     clamp_col;
  logic [RW-1:0]     clamp_row;
  logic [ADDR_W-1:0] cursor_idx;
  logic [ADDR_W-1:0] read_idx;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  // Item decode and address arithmetic.
  always_comb begin
    is_put     = (item_mode == MODE_PUT);
    is_newline = (item_char == CHAR_LF) || (item_char == CHAR_CR);
    col_last   = (cur_col == CW'(SCREEN_COLUMNS - 1));
    row_last   = (cur_row == RW'(SCREEN_LINES - 1));
    put_wr     = cmd.exec && is_put && !is_newline;
    clamp_col  = (32'(item_col) >= 32'(SCREEN_COLUMNS)) ? CW'(SCREEN_COLUMNS - 1)
                                                        : CW'(item_col);
    clamp_row  = (32'(item_row) >= 32'(SCREEN_LINES)) ? RW'(SCREEN_LINES - 1)
                                                      : RW'(item_row);
    cursor_idx = ADDR_W'(32'(cur_row) * 32'(SCREEN_COLUMNS) + 32'(cur_col));
    read_idx   = ADDR_W'(32'(clamp_row) * 32'(SCREEN_COLUMNS) + 32'(clamp_col));
  end

  assign status.scroll_needed = is_put && (is_newline || col_last) && row_last;
  assign status.move_end      = (cnt == ADDR_W'(MOVE_COUNT - 1));
  assign status.cnt_end       = (cnt == ADDR_W'(CELL_COUNT - 1));

  // Single write port: the delayed scroll stage, the reset sweep or a put.
  always_comb begin
    mem_we    = pend_valid || cmd.clear_step || put_wr;
    mem_waddr = cursor_idx;
    mem_wdata = {fill_attr, item_char};
    if (pend_valid) begin
      mem_waddr = pend_addr;
      mem_wdata = pend_fill ? {fill_attr, 8'h00} : rd_data;
    end else if (cmd.clear_step) begin
      mem_waddr = cnt;
      mem_wdata = 16'h0000;
    end
  end

  // Single read port: one row ahead during a scroll, else the read-cell target.
  assign mem_re    = cmd.copy_step || (cmd.exec && (item_mode == MODE_READ));
  assign mem_raddr = cmd.copy_step ? ADDR_W'(32'(cnt) + 32'(SCREEN_COLUMNS)) : read_idx;

  // Screen store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  // Control registers: attribute, cursor, sweep counter, delayed write stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_attr  <= 8'd7;
      cur_col    <= '0;
      cur_row    <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) fill_attr <= cfg_wr_data;
      pend_valid <= cmd.copy_step || cmd.fill_step;
      if (cmd.exec) begin
        cnt <= '0;
        case (item_mode)
          MODE_PUT: begin
            if (is_newline || col_last) begin
              cur_col <= '0;
              if (!row_last) cur_row <= cur_row + 1'b1;
            end else begin
              cur_col <= cur_col + 1'b1;
            end
          end
          MODE_SET: begin
            cur_col <= clamp_col;
            cur_row <= clamp_row;
          end
          default: begin
          end
        endcase
      end else if (cmd.clear_step || cmd.copy_step || cmd.fill_step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Payload registers: latched item, scroll marker, delayed write address.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode <= in_mode;
      item_char <= in_char_code;
      item_col  <= in_col;
      item_row  <= in_row;
    end
    if (cmd.exec) scroll_flag <= status.scroll_needed;
    pend_addr <= cnt;
    pend_fill <= cmd.fill_step;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cursor_x  <= 7'(cur_col);
      cursor_y  <= 5'(cur_row);
      cell_char <= (item_mode == MODE_READ) ? rd_data[7:0]  : 8'h00;
      cell_attr <= (item_mode == MODE_READ) ? rd_data[15:8] : 8'h00;
      scrolled  <= (item_mode == MODE_PUT) && scroll_flag;
    end
  end

  // The delayed scroll write must never collide with another write.
  assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !(cmd.clear_step || put_wr))
    else $error("scroll write collides with another store write");

  // The cursor always stays on the screen.
  assert property (@(posedge clk) disable iff (rst)
    (32'(cur_col) < 32'(SCREEN_COLUMNS)) && (32'(cur_row) < 32'(SCREEN_LINES)))
    else $error("cursor left the screen");

  // A scroll leaves the cursor at the start of the bottom row.
  assert property (@(posedge clk) disable iff (rst)
    cmd.exec && status.scroll_needed |=> (cur_col == '0) && row_last)
    else $error("scroll left the cursor off the bottom row start");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the text console writer (text_console_writer).
// A shadow of the screen store and cursor predicts every result item and the
// master stream is checked against it. Depends on tcw_pkg and the RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLS          = 80;
  localparam int LINES         = 25;
  localparam int CELL_COUNT    = COLS * LINES;
  localparam int SCROLL_BUDGET = 120;    // keeps the slow scroll passes bounded
  localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;      // margin past the per-item turnaround
  localparam int IDLE_LIMIT    = 12000;  // covers a clearing or scroll pass plus the hold-off
  localparam int PHASE_ITEMS   = 350;

  // The package has no name for the fourth mode code, which leaves everything alone.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
  } console_item_t;

  // Result layout on m_tdata, highest field first.
  typedef struct packed {
    logic [2:0] pad;
    logic       scrolled;
    logic [7:0] cell_attr;
    logic [7:0] cell_char;
    logic [4:0] cursor_y;
    logic [6:0] cursor_x;
  } console_result_t;

  // Shadow of the screen and cursor, plus the results still awaited on the output.
  class screen_shadow;
    logic [15:0]     cells [CELL_COUNT];
    logic [6:0]      col_q;
    logic [4:0]      row_q;
    logic [7:0]      attr_q;
    console_result_t awaited [$];
    int              errors;
    int              scroll_count;

    function new();
      foreach (cells[i]) cells[i] = 16'h0000;
      col_q        = '0;
      row_q        = '0;
      attr_q       = 8'd7;
      errors       = 0;
      scroll_count = 0;
    endfunction

    function int clamp_coord(int v, int limit);
      return (v >= limit) ? limit - 1 : v;
    endfunction

    // Go to column 0 of the next row, scrolling the screen when past the bottom.
    function bit advance_row();
      col_q = '0;
      if (row_q == LINES - 1) begin
        for (int i = 0; i < CELL_COUNT - COLS; i++) cells[i] = cells[i + COLS];
        for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++) cells[i] = {attr_q, 8'h00};
        scroll_count++;
        return 1'b1;
      end
      row_q = row_q + 5'd1;
      return 1'b0;
    endfunction

    // Apply one accepted input item and queue the result it must produce.
    function void record_item(console_item_t it);
      console_result_t want;
      logic [15:0]     cell_word;
      want = '0;
      case (it.mode)
        MODE_PUT: begin
          if (it.char_code == CHAR_LF || it.char_code == CHAR_CR) begin
            want.scrolled = advance_row();
          end else begin
            cells[int'(row_q) * COLS + int'(col_q)] = {attr_q, it.char_code};
            if (col_q == COLS - 1) want.scrolled = advance_row();
            else col_q = col_q + 7'd1;
          end
        end
        MODE_SET: begin
          col_q = 7'(clamp_coord(it.col, COLS));
          row_q = 5'(clamp_coord(it.row, LINES));
        end
        MODE_READ: begin
          cell_word = cells[clamp_coord(it.row, LINES) * COLS + clamp_coord(it.col, COLS)];
          want.cell_char = cell_word[7:0];
          want.cell_attr = cell_word[15:8];
        end
        default: begin
        end
      endcase
      want.cursor_x = col_q;
      want.cursor_y = row_q;
      awaited.push_back(want);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Check one accepted result transfer against the oldest awaited result.
    function void check_output(logic [31:0] data);
      console_result_t got;
      console_result_t want;
      got = data;
      if (awaited.size() == 0) begin
        $error("result transfer 0x%08h arrived with no result awaited", data);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("cursor_x", want.cursor_x, got.cursor_x);
      compare_field("cursor_y", want.cursor_y, got.cursor_y);
      compare_field("cell_char", want.cell_char, got.cell_char);
      compare_field("cell_attr", want.cell_attr, got.cell_attr);
      compare_field("scrolled", want.scrolled, got.scrolled);
      compare_field("pad", want.pad, got.pad);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  screen_shadow board = new();
  bit           hold_req = 1'b0;
  int           idle_cycles = 0;

  text_console_writer #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_LINES  (LINES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result monitor: every accepted output transfer is checked.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_output(m_tdata);
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: runs of ready broken by short stalls, with the occasional long
  // stretch of no stalls, and one long hold-off on request.
  initial begin : receiver
    int run_left;
    int stall_left;
    run_left   = 0;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 16);
          stall_left = $urandom_range(1, 8);
        end
      end
    end
  end

  function automatic console_item_t item(logic [1:0] mode, logic [7:0] ch,
                                         logic [6:0] col, logic [4:0] row);
    console_item_t it;
    it.mode      = mode;
    it.char_code = ch;
    it.col       = col;
    it.row       = row;
    return it;
  endfunction

  // Mostly on-screen coordinates, sometimes anywhere in the field's width.
  function automatic int rand_coord(int limit, int top);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, top) : $urandom_range(0, limit - 1);
  endfunction

  // Random item, steered by the shadow cursor so that scrolls stay within budget.
  function automatic console_item_t make_item();
    console_item_t it;
    int            pick;
    bit            line_end;
    pick = $urandom_range(0, 99);
    it   = item(MODE_PUT, 8'($urandom_range(0, 255)), 7'(rand_coord(COLS, 127)),
                5'(rand_coord(LINES, 31)));
    if (pick < 50) begin
      if ($urandom_range(0, 9) == 0) it.char_code = $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
      line_end = (it.char_code == CHAR_LF || it.char_code == CHAR_CR
                  || board.col_q == COLS - 1);
      if (board.row_q == LINES - 1 && line_end && board.scroll_count >= SCROLL_BUDGET) begin
        it.mode = MODE_SET;
        it.row  = 5'($urandom_range(0, LINES - 2));
      end
    end else if (pick < 65) begin
      it.mode = MODE_SET;
    end else if (pick < 95) begin
      it.mode = MODE_READ;
      // Half the reads look at the cell just written.
      if ($urandom_range(0, 1) == 1 && board.col_q > 0) begin
        it.col = board.col_q - 7'd1;
        it.row = board.row_q;
      end
    end else begin
      it.mode = MODE_UNUSED;
    end
    return it;
  endfunction

  // Offer one item from a falling edge; returns at the falling edge after its transfer.
  task automatic drive_item(console_item_t it);
    s_tvalid <= 1'b1;
    s_tuser  <= it.mode;
    s_tdata  <= {4'b0000, it.row, it.col, it.char_code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.record_item(it);
    @(negedge clk);
  endtask

  // Stop offering and wait until every awaited result has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.awaited.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_fill_attr(logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    board.attr_q = value;
  endtask

  // Random items in bursts of random length, mostly with random gaps between them.
  task automatic run_random(int count, bit with_pressure);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 7) == 0) begin
          burst_left = 120;
          gap        = 0;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap        = $urandom_range(1, 9);
        end
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      // Halfway through, hold the receiver off and keep offering back to back.
      if (with_pressure && n == count / 2) begin
        hold_req = 1'b1;
        repeat (12) drive_item(make_item());
      end
      drive_item(make_item());
      burst_left--;
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 8'h00;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed items with the reset fill attribute: edges of every field,
    // every mode, wrap, scrolls and clamping of out-of-range coordinates.
    drive_item(item(MODE_READ, 8'hFF, 7'd0, 5'd0));
    drive_item(item(MODE_UNUSED, 8'hFF, 7'd127, 5'd31));
    drive_item(item(MODE_PUT, 8'h41, 7'd0, 5'd0));
    drive_item(item(MODE_READ, 8'h00, 7'd0, 5'd0));
    drive_item(item(MODE_PUT, 8'h00, 7'd127, 5'd31));
    drive_item(item(MODE_PUT, 8'hFF, 7'd0, 5'd0));
    drive_item(item(MODE_PUT, CHAR_CR, 7'd0, 5'd0));
    drive_item(item(MODE_PUT, CHAR_LF, 7'd0, 5'd0));
    drive_item(item(MODE_SET, 8'h00, 7'd127, 5'd31));
    drive_item(item(MODE_PUT, 8'h5A, 7'd0, 5'd0));
    drive_item(item(MODE_READ, 8'h00, 7'd79, 5'd23));
    drive_item(item(MODE_READ, 8'h00, 7'd127, 5'd31));
    drive_item(item(MODE_READ, 8'h00, 7'd0, 5'd0));
    drive_item(item(MODE_PUT, CHAR_LF, 7'd0, 5'd0));
    drive_item(item(MODE_PUT, CHAR_CR, 7'd0, 5'd0));
    drive_item(item(MODE_SET, 8'h00, 7'd79, 5'd5));
    drive_item(item(MODE_PUT, 8'h78, 7'd0, 5'd0));
    drive_item(item(MODE_READ, 8'h00, 7'd80, 5'd5));
    drive_item(item(MODE_SET, 8'h00, 7'd0, 5'd24));
    drive_item(item(MODE_READ, 8'h00, 7'd0, 5'd31));
    drive_item(item(MODE_SET, 8'h00, 7'd80, 5'd25));
    drive_item(item(MODE_UNUSED, 8'h00, 7'd0, 5'd0));
    drive_item(item(MODE_SET, 8'h00, 7'd0, 5'd0));

    // Random phases, each under its own fill attribute.
    drain();
    write_fill_attr(8'hFF);
    run_random(PHASE_ITEMS, 1'b0);
    drain();
    write_fill_attr(8'h00);
    run_random(PHASE_ITEMS, 1'b1);
    drain();
    write_fill_attr(8'($urandom_range(1, 254)));
    run_random(PHASE_ITEMS, 1'b0);
    drain();
    write_fill_attr(8'($urandom_range(0, 255)));
    run_random(PHASE_ITEMS, 1'b0);
    drain();

    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (board.awaited.size() != 0) $error("%0d results never arrived", board.awaited.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
